FILE: rtl/sfr_pkg.sv
// Package for the serial frame receiver: frame layout constants, sync reset values,
// configuration register indexes, hunt phase type and the CRC-16/MODBUS byte update.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int FRAME_BYTES_DEF = 32;
    localparam int HEADER_BYTES    = 4;
    localparam int DATA_BYTES_DEF  = 16;
    localparam int DATA_SLOTS      = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'b001,
        PH_SECOND  = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/serial_frame_receiver_crc16_unit.sv
// Top level of the serial frame receiver: sync hunt, fixed frame collection and
// CRC-16/MODBUS check in one registered pass per byte.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one received byte per item (s_rx_byte) with a line error flag
//   (s_rx_error). An error byte abandons any partial sync or frame.
//   m_ channel: one item per complete frame, good or bad: command type, length
//   clamped to DATA_BYTES, data bytes in m_data_low / m_data_high (byte 0 in
//   bits 7:0, slots beyond DATA_BYTES zero) and m_crc_ok.
//   cfg channel: cfg_index 0 writes sync_first, 1 writes sync_second, others are
//   dropped. Always ready; write only while no byte is in flight.
// Timing:
//   A byte is registered in the input register when it is accepted and is
//   processed from there into the frame state; the last frame byte loads the
//   result register. One byte is accepted every cycle unless a result waits
//   on m_ready; the byte-wide CRC update and the result register set that rate.
// Stall:
//   While a result waits on m_ready, one more byte is taken into the input
//   register, then s_ready drops until the result is taken.
// Reset:
//   aresetn low clears both stages, restores the sync bytes to 0xAA / 0x55 and
//   starts hunting for the first sync byte.
module serial_frame_receiver_crc16_unit #(
    parameter int FRAME_BYTES = sfr_pkg::FRAME_BYTES_DEF,
    parameter int DATA_BYTES  = sfr_pkg::DATA_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                   cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    input  logic                         s_rx_error,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_command_type,
    output logic [4:0]                   m_payload_length,
    output logic [63:0]                  m_data_low,
    output logic [63:0]                  m_data_high,
    output logic                         m_crc_ok
);
    import sfr_pkg::*;

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_START   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CMD     = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CRC_END = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
    localparam logic [4:0]       LEN_MAX     = 5'(DATA_BYTES);

    logic [7:0]       sync_first_reg, sync_second_reg;

    logic             in_vld_reg, in_vld_next;
    logic [7:0]       in_byte_reg;
    logic             in_err_reg;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic [7:0]       store_reg [DATA_BYTES];

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_cmd_reg;
    logic [4:0]       m_len_reg;
    logic [63:0]      m_lo_reg, m_hi_reg;
    logic             m_ok_reg;

    logic             advance, fire, emit, collecting;
    logic [63:0]      data_lo, data_hi;
    logic [15:0]      crc_recv;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !in_vld_reg || advance;
    assign fire      = in_vld_reg && advance;

    assign m_valid          = m_valid_reg;
    assign m_command_type   = m_cmd_reg;
    assign m_payload_length = m_len_reg;
    assign m_data_low       = m_lo_reg;
    assign m_data_high      = m_hi_reg;
    assign m_crc_ok         = m_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_err_reg  <= s_rx_error;
        end
    end

    assign collecting = fire && !in_err_reg && (phase_reg == PH_COLLECT);
    assign crc_recv   = {in_byte_reg, crc_lo_reg};

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        crc_lo_next = crc_lo_reg;
        emit        = 1'b0;
        if (fire) begin
            if (in_err_reg) begin
                phase_next = PH_FIRST;
                pos_next   = '0;
                crc_next   = CRC_INIT;
            end else begin
                case (phase_reg)
                    PH_SECOND: begin
                        if (in_byte_reg == sync_second_reg) begin
                            phase_next = PH_COLLECT;
                            pos_next   = POS_START;
                            crc_next   = CRC_INIT;
                        end else if (in_byte_reg != sync_first_reg) begin
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_COLLECT: begin
                        if (pos_reg == POS_CMD) begin
                            cmd_next = in_byte_reg;
                        end
                        if (pos_reg == POS_LEN) begin
                            len_next = in_byte_reg;
                        end
                        if (pos_reg <= POS_CRC_END) begin
                            crc_next = crc_byte(crc_reg, in_byte_reg);
                        end
                        if (pos_reg == POS_CRC_LO) begin
                            crc_lo_next = in_byte_reg;
                        end
                        if (pos_reg >= POS_LAST) begin
                            emit       = 1'b1;
                            phase_next = PH_FIRST;
                            pos_next   = '0;
                            crc_next   = CRC_INIT;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    default: begin
                        phase_next = (in_byte_reg == sync_first_reg) ? PH_SECOND : PH_FIRST;
                        pos_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            cmd_reg    <= '0;
            len_reg    <= '0;
            crc_lo_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    for (genvar i = 0; i < DATA_BYTES; i++) begin : g_store
        always_ff @(posedge aclk) begin
            if (collecting && (pos_reg == POS_W'(HEADER_BYTES + i))) begin
                store_reg[i] <= in_byte_reg;
            end
        end
    end

    for (genvar i = 0; i < 8; i++) begin : g_data
        if (i < DATA_BYTES) begin : g_lo
            assign data_lo[8*i +: 8] = store_reg[i];
        end else begin : g_lo_zero
            assign data_lo[8*i +: 8] = 8'h00;
        end
        if (i + 8 < DATA_BYTES) begin : g_hi
            assign data_hi[8*i +: 8] = store_reg[i + 8];
        end else begin : g_hi_zero
            assign data_hi[8*i +: 8] = 8'h00;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (fire && emit) begin
            m_cmd_reg <= cmd_reg;
            m_len_reg <= (len_reg > 8'(DATA_BYTES)) ? LEN_MAX : len_reg[4:0];
            m_lo_reg  <= data_lo;
            m_hi_reg  <= data_hi;
            m_ok_reg  <= (crc_recv == crc_reg);
        end
    end

    a_ready_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(fire))
        else $error("result appeared without a processed item");

    a_collect_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COLLECT) |-> (pos_reg >= POS_START && pos_reg <= POS_LAST))
        else $error("frame position out of range");

    a_restart_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |=> (phase_reg == PH_FIRST && crc_reg == CRC_INIT && m_valid_reg))
        else $error("hunt not restarted after a frame");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_receiver_crc16_unit: directed frames from a table, then random
// byte streams under several sync settings, each frame result checked against a bench model
// or the pinned row's own result. Depends on sfr_pkg and the receiver RTL.

module testbench;
    import sfr_pkg::*;

    localparam int FRAME_LEN     = FRAME_BYTES_DEF;
    localparam int DATA_LEN      = DATA_BYTES_DEF;
    localparam int CRC_LAST      = FRAME_LEN - 3;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_MAX      = 13;
    localparam int LONG_HOLD     = 240;
    localparam int ROWS          = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [7:0]  command;
        logic [4:0]  length;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        ok;
    } frame_result_t;

    typedef enum logic [2:0] {
        LEAD_CLEAN,
        LEAD_NOISE,
        LEAD_REPEAT,
        LEAD_FALSE,
        LEAD_ERR_SYNC
    } lead_t;

    typedef struct packed {
        lead_t         lead;
        logic [7:0]    cmd;
        logic [7:0]    len;
        logic [7:0]    fill;
        logic [7:0]    stride;
        logic          crc_good;
        logic [5:0]    cut;
        logic          pinned;
        frame_result_t want;
    } frame_row_t;

    frame_row_t directed_rows [ROWS] = '{
        '{LEAD_CLEAN,    8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'h00, 5'd0,  64'h0, 64'h0, 1'b1}},
        '{LEAD_CLEAN,    8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'hFF, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
        '{LEAD_CLEAN,    8'h01, 8'h10, 8'h5A, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'h01, 5'd16, 64'h5A5A_5A5A_5A5A_5A5A, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1}},
        '{LEAD_CLEAN,    8'h02, 8'h11, 8'hA5, 8'h00, 1'b0, 6'd0,  1'b1,
          '{8'h02, 5'd16, 64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0}},
        '{LEAD_CLEAN,    8'h0F, 8'h0F, 8'h00, 8'h01, 1'b1, 6'd0,  1'b1,
          '{8'h0F, 5'd15, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 1'b1}},
        '{LEAD_NOISE,    8'h03, 8'h01, 8'h10, 8'h11, 1'b1, 6'd0,  1'b0, '0},
        '{LEAD_REPEAT,   8'hAA, 8'h55, 8'hAA, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'hAA, 5'd16, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1}},
        '{LEAD_FALSE,    8'h55, 8'h08, 8'h55, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'h55, 5'd8,  64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b1}},
        '{LEAD_ERR_SYNC, 8'h10, 8'h01, 8'h80, 8'h01, 1'b1, 6'd0,  1'b0, '0},
        '{LEAD_CLEAN,    8'h20, 8'h04, 8'h33, 8'h00, 1'b1, 6'd1,  1'b0, '0},
        '{LEAD_CLEAN,    8'h21, 8'h04, 8'h44, 8'h00, 1'b1, 6'd2,  1'b0, '0},
        '{LEAD_CLEAN,    8'h22, 8'h04, 8'h66, 8'h00, 1'b1, 6'd20, 1'b0, '0},
        '{LEAD_CLEAN,    8'h23, 8'h04, 8'h77, 8'h00, 1'b1, 6'd31, 1'b0, '0},
        '{LEAD_CLEAN,    8'h7F, 8'h07, 8'h01, 8'h02, 1'b0, 6'd0,  1'b0, '0},
        '{LEAD_CLEAN,    8'h80, 8'h10, 8'hFE, 8'h00, 1'b1, 6'd0,  1'b1,
          '{8'h80, 5'd16, 64'hFEFE_FEFE_FEFE_FEFE, 64'hFEFE_FEFE_FEFE_FEFE, 1'b1}},
        '{LEAD_CLEAN,    8'hAA, 8'h55, 8'hAA, 8'hAB, 1'b1, 6'd0,  1'b0, '0}
    };

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte     = '0;
    logic                 s_rx_error    = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [7:0]           m_command_type;
    logic [4:0]           m_payload_length;
    logic [63:0]          m_data_low;
    logic [63:0]          m_data_high;
    logic                 m_crc_ok;

    // bench copy of the receiver state and its sync registers
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    phase_t      hunt_ph;
    logic [5:0]  hunt_pos;
    logic [15:0] crc_run;
    logic [7:0]  cmd_seen;
    logic [7:0]  len_seen;
    logic [7:0]  crc_low_seen;
    logic [7:0]  data_seen [DATA_SLOTS];

    frame_result_t frames_due [$];
    frame_result_t pinned_frames [$];

    int bytes_sent     = 0;
    int errors_sent    = 0;
    int frames_checked = 0;
    int bad_crc_seen   = 0;
    int mismatches     = 0;
    int regs_written   = 0;
    int tx_idle_max    = 0;
    int rx_idle_max    = 0;
    int long_hold      = 0;

    serial_frame_receiver_crc16_unit #(
        .FRAME_BYTES (FRAME_LEN),
        .DATA_BYTES  (DATA_LEN)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_rx_error       (s_rx_error),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_command_type   (m_command_type),
        .m_payload_length (m_payload_length),
        .m_data_low       (m_data_low),
        .m_data_high      (m_data_high),
        .m_crc_ok         (m_crc_ok)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus_update(input logic [15:0] acc,
                                                        input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void rearm_hunt();
        hunt_ph  = PH_FIRST;
        hunt_pos = '0;
        crc_run  = CRC_INIT;
    endfunction

    function automatic bit track_rx_byte(input logic [7:0] b, input logic err,
                                         output frame_result_t res);
        int p;
        int i;
        res = '0;
        if (err) begin
            rearm_hunt();
            return 1'b0;
        end
        if (hunt_ph == PH_SECOND) begin
            if (b == sync_b) begin
                hunt_ph  = PH_COLLECT;
                hunt_pos = 6'd2;
                crc_run  = CRC_INIT;
            end else if (b != sync_a) begin
                hunt_ph = PH_FIRST;
            end
            return 1'b0;
        end
        if (hunt_ph != PH_COLLECT) begin
            hunt_ph  = (b == sync_a) ? PH_SECOND : PH_FIRST;
            hunt_pos = '0;
            return 1'b0;
        end
        p = hunt_pos;
        if (p == 2) cmd_seen = b;
        if (p == 3) len_seen = b;
        if (p >= HEADER_BYTES && p < HEADER_BYTES + DATA_LEN) data_seen[p - HEADER_BYTES] = b;
        if (p <= CRC_LAST) crc_run = crc16_modbus_update(crc_run, b);
        if (p == FRAME_LEN - 2) crc_low_seen = b;
        if (p >= FRAME_LEN - 1) begin
            res.command = cmd_seen;
            res.length  = (len_seen > DATA_LEN) ? 5'(DATA_LEN) : len_seen[4:0];
            for (i = 0; i < 8; i++) begin
                if (i < DATA_LEN) res.lo[8*i +: 8] = data_seen[i];
                if (i + 8 < DATA_LEN) res.hi[8*i +: 8] = data_seen[i + 8];
            end
            res.ok = ({b, crc_low_seen} == crc_run);
            rearm_hunt();
            return 1'b1;
        end
        hunt_pos = 6'(p + 1);
        return 1'b0;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic err);
        int            gap;
        frame_result_t res;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_rx_byte  <= b;
        s_rx_error <= err;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (err) errors_sent++;
        if (track_rx_byte(b, err, res)) begin
            if (pinned_frames.size() > 0) res = pinned_frames.pop_front();
            frames_due.insert(frames_due.size(), res);
        end
        @(negedge aclk);
    endtask

    task automatic send_frame(input lead_t lead, input logic [7:0] cmd, input logic [7:0] len,
                              input logic [127:0] body, input bit crc_good, input int cut);
        logic [7:0]  fb [FRAME_LEN];
        logic [7:0]  junk;
        logic [15:0] crc;
        int          k;
        case (lead)
            LEAD_NOISE: begin
                repeat ($urandom_range(1, 4)) begin
                    do junk = 8'($urandom); while (junk == sync_a);
                    send_item(junk, 1'b0);
                end
            end
            LEAD_REPEAT: begin
                repeat (2) send_item(sync_a, 1'b0);
            end
            LEAD_FALSE: begin
                do junk = 8'($urandom); while (junk == sync_a || junk == sync_b);
                send_item(sync_a, 1'b0);
                send_item(junk, 1'b0);
            end
            LEAD_ERR_SYNC: begin
                send_item(sync_a, 1'b0);
                send_item(8'($urandom), 1'b1);
                send_item(sync_b, 1'b0);
            end
            default: begin
            end
        endcase
        fb[0] = sync_a;
        fb[1] = sync_b;
        fb[2] = cmd;
        fb[3] = len;
        for (k = 0; k < DATA_LEN; k++) fb[HEADER_BYTES + k] = body[8*k +: 8];
        for (k = HEADER_BYTES + DATA_LEN; k < FRAME_LEN - 2; k++) fb[k] = 8'($urandom);
        crc = CRC_INIT;
        for (k = 2; k <= CRC_LAST; k++) crc = crc16_modbus_update(crc, fb[k]);
        if (!crc_good) crc ^= 16'($urandom_range(1, 16'hFFFF));
        fb[FRAME_LEN - 2] = crc[7:0];
        fb[FRAME_LEN - 1] = crc[15:8];
        for (k = 0; k < ((cut > 0) ? cut : FRAME_LEN); k++) send_item(fb[k], 1'b0);
        if (cut > 0) send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_random_frame(input int cut);
        logic [7:0] len;
        lead_t      lead;
        int         pick;
        case ($urandom_range(0, 7))
            0:       len = 8'd0;
            1:       len = 8'(DATA_LEN);
            2:       len = 8'(DATA_LEN + 1);
            3:       len = 8'hFF;
            default: len = 8'($urandom);
        endcase
        pick = $urandom_range(0, 9);
        lead = (pick < 5) ? LEAD_CLEAN : (pick < 7) ? LEAD_NOISE :
               (pick == 7) ? LEAD_REPEAT : (pick == 8) ? LEAD_FALSE : LEAD_ERR_SYNC;
        send_frame(lead, 8'($urandom), len, {$urandom, $urandom, $urandom, $urandom},
                   $urandom_range(0, 4) != 0, cut);
    endtask

    task automatic settle(input int extra);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_SYNC_FIRST) sync_a = val;
        else if (idx == CFG_SYNC_SECOND) sync_b = val;
        regs_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_frames(input int n_items);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                send_random_frame(0);
            end else if (pick < 17) begin
                send_random_frame($urandom_range(1, FRAME_LEN - 1));
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 6)) send_item(8'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                settle(1);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input frame_result_t want,
                                 input frame_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] frame result %s", $realtime, what);
            $display("    expected cmd %h len %0d data %h_%h crc_ok %b",
                     want.command, want.length, want.hi, want.lo, want.ok);
            $display("    actual   cmd %h len %0d data %h_%h crc_ok %b",
                     got.command, got.length, got.hi, got.lo, got.ok);
        end
    endtask

    initial begin : result_sink
        int            stall;
        frame_result_t got;
        frame_result_t want;
        string         bad;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                stall     = long_hold;
                long_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_idle_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_command_type, m_payload_length, m_data_low, m_data_high, m_crc_ok};
            if (frames_due.size() == 0) begin
                flag_mismatch("with none pending", '0, got);
            end else begin
                want = frames_due.pop_front();
                bad  = "";
                if (got.command !== want.command) bad = {bad, " command_type"};
                if (got.length !== want.length) bad = {bad, " payload_length"};
                if (got.lo !== want.lo) bad = {bad, " data_low"};
                if (got.hi !== want.hi) bad = {bad, " data_high"};
                if (got.ok !== want.ok) bad = {bad, " crc_ok"};
                if (bad != "") flag_mismatch({"differs in", bad}, want, got);
                frames_checked++;
                if (got.ok !== 1'b1) bad_crc_seen++;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int             r;
        int             i;
        frame_row_t     row;
        logic [127:0]   body;
        sync_a       = SYNC_FIRST_RST;
        sync_b       = SYNC_SECOND_RST;
        cmd_seen     = '0;
        len_seen     = '0;
        crc_low_seen = '0;
        for (i = 0; i < DATA_SLOTS; i++) data_seen[i] = '0;
        rearm_hunt();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
        for (r = 0; r < ROWS; r++) begin
            row  = directed_rows[r];
            body = '0;
            for (i = 0; i < DATA_LEN; i++) body[8*i +: 8] = row.fill + 8'(i) * row.stride;
            if (row.pinned) pinned_frames.insert(pinned_frames.size(), row.want);
            send_frame(row.lead, row.cmd, row.len, body, row.crc_good, int'(row.cut));
        end

        settle(SETTLE_CYCLES);
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h00);
        random_frames(130);

        // hold off the result side while frames keep streaming in
        long_hold   = LONG_HOLD;
        tx_idle_max = 0;
        repeat (10) send_random_frame(0);
        settle(1);
        tx_idle_max = IDLE_MAX;

        settle(SETTLE_CYCLES);
        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        random_frames(130);

        settle(SETTLE_CYCLES);
        write_reg(CFG_SYNC_FIRST, 8'hFF);
        write_reg(CFG_SYNC_SECOND, 8'h00);
        random_frames(120);

        settle(SETTLE_CYCLES);
        write_reg(CFG_SYNC_FIRST, 8'h7E);
        write_reg(CFG_SYNC_SECOND, 8'h7E);
        random_frames(100);

        settle(SETTLE_CYCLES);
        write_reg(CFG_SYNC_SECOND, 8'($urandom));
        write_reg(CFG_SYNC_FIRST, 8'($urandom));
        random_frames(100);

        settle(SETTLE_CYCLES);
        $display("Streamed %0d bytes (%0d flagged as line errors); %0d frame results checked,",
                 bytes_sent, errors_sent, frames_checked);
        $display("%0d of them with a CRC mismatch, across five sync pairs and %0d register writes.",
                 bad_crc_seen, regs_written);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sfr_pkg.sv
rtl/serial_frame_receiver_crc16_unit.sv
sim/testbench.sv
